### hdl/sptg_pkg.sv
`default_nettype none
package sptg_pkg;

  localparam int MAX_ELEMENTS = 1024;
  localparam int LEVELS       = 11;
  localparam int IDX_W        = 10;
  localparam int VAL_W        = 31;
  localparam int LEN_W        = 11;
  localparam int LVL_W        = 4;
  localparam int SH_W         = 5;
  localparam int TBL_AW       = LVL_W + IDX_W;
  localparam int TBL_DEPTH    = 1 << TBL_AW;

  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_QUERY  = 2'd1,
    KIND_EXTEND = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    RD_RB_A = 2'd0,
    RD_RB_B = 2'd1,
    RD_Q_A  = 2'd2,
    RD_Q_B  = 2'd3
  } rd_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_RB_CHK,
    ST_RB_RA,
    ST_RB_RB,
    ST_RB_CB,
    ST_RB_WAIT,
    ST_OP,
    ST_Q_RA,
    ST_Q_RB,
    ST_Q_CB,
    ST_Q_WAIT,
    ST_EX_CHK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic    latch_in;
    logic    wr_load;
    logic    rb_init;
    logic    rb_next_lv;
    logic    rb_write;
    logic    set_valid;
    rd_sel_t rd_sel;
    logic    cap_a;
    logic    gcd_start;
    logic    q_setup;
    logic    ex_init;
    logic    ex_setup;
    logic    ex_update;
    logic    out_fire;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  err;
    logic  valid;
    logic  rb_lv_end;
    logic  rb_row_ok;
    logic  gcd_done;
    logic  ex_more;
  } stat_t;

  // floor(log2(x)) capped at the top table level
  function automatic logic [LVL_W-1:0] flog2(input logic [LEN_W-1:0] x);
    logic [LVL_W-1:0] r;
    r = '0;
    for (int i = 0; i < LEN_W; i++) begin
      if (x[i]) r = LVL_W'(i);
    end
    if (r > LVL_W'(LEVELS - 1)) r = LVL_W'(LEVELS - 1);
    return r;
  endfunction

endpackage
`default_nettype wire

### hdl/sptg_ram.sv
`default_nettype none
module sptg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### hdl/sptg_gcd.sv
`default_nettype none
module sptg_gcd (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [sptg_pkg::VAL_W-1:0] in_a,
  input  wire logic [sptg_pkg::VAL_W-1:0] in_b,
  output logic                           done,
  output logic      [sptg_pkg::VAL_W-1:0] result
);
  import sptg_pkg::*;

  logic [VAL_W-1:0] x;
  logic [VAL_W-1:0] y;
  logic [SH_W-1:0]  k;
  logic             run;

  // binary gcd: one shift or one subtract per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        x   <= in_a;
        y   <= in_b;
        k   <= '0;
        run <= 1'b1;
      end else if (run) begin
        if (x == '0) begin
          result <= y << k;
          run    <= 1'b0;
          done   <= 1'b1;
        end else if (y == '0) begin
          result <= x << k;
          run    <= 1'b0;
          done   <= 1'b1;
        end else if (!x[0] && !y[0]) begin
          x <= x >> 1;
          y <= y >> 1;
          k <= k + SH_W'(1);
        end else if (!x[0]) begin
          x <= x >> 1;
        end else if (!y[0]) begin
          y <= y >> 1;
        end else if (x >= y) begin
          x <= x - y;
        end else begin
          y <= y - x;
        end
      end
    end
  end

endmodule
`default_nettype wire

### hdl/sptg_dp.sv
`default_nettype none
module sptg_dp (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire sptg_pkg::cmd_t             cmd,
  output sptg_pkg::stat_t                 stat,
  input  wire logic [1:0]                 kind,
  input  wire logic [sptg_pkg::IDX_W-1:0] first_index,
  input  wire logic [sptg_pkg::IDX_W-1:0] second_index,
  input  wire logic [sptg_pkg::VAL_W-1:0] value,
  input  wire logic                       cfg_we,
  input  wire logic [sptg_pkg::LEN_W-1:0] cfg_data,
  output logic                            done,
  output logic      [sptg_pkg::VAL_W-1:0] gcd_result,
  output logic      [sptg_pkg::IDX_W-1:0] end_index,
  output logic                            error
);
  import sptg_pkg::*;

  kind_t             kind_q;
  logic [IDX_W-1:0]  a_q;
  logic [IDX_W-1:0]  b_q;
  logic [VAL_W-1:0]  v_q;
  logic [LEN_W-1:0]  len;
  logic              valid;
  logic [LEN_W-1:0]  n;
  logic              err;

  logic [LVL_W-1:0]  rb_lv;
  logic [LEN_W-1:0]  rb_i;
  logic [LEN_W-1:0]  rb_span;
  logic [LEN_W-1:0]  rb_half;

  logic [IDX_W-1:0]  ql;
  logic [IDX_W-1:0]  qr;
  logic [LEN_W-1:0]  qlen;
  logic [LVL_W-1:0]  qs;
  logic [LEN_W-1:0]  qspan;
  logic [LEN_W-1:0]  qb;

  logic [LEN_W-1:0]  lo;
  logic [LEN_W-1:0]  hiex;
  logic [LEN_W-1:0]  mid;
  logic [IDX_W-1:0]  ans;

  logic              we;
  logic [TBL_AW-1:0] waddr;
  logic [VAL_W-1:0]  wdata;
  logic [TBL_AW-1:0] raddr;
  logic [VAL_W-1:0]  rdata;
  logic [VAL_W-1:0]  op_a;
  logic              gdone;
  logic [VAL_W-1:0]  gres;

  assign n = (len > LEN_W'(MAX_ELEMENTS)) ? LEN_W'(MAX_ELEMENTS) : len;

  always_comb begin
    case (kind_q)
      KIND_LOAD:   err = !({1'b0, a_q} < n);
      KIND_QUERY:  err = !(a_q <= b_q && {1'b0, b_q} < n);
      KIND_EXTEND: err = !(b_q <= a_q && {1'b0, a_q} < n);
      default:     err = 1'b1;
    endcase
  end

  assign rb_span = LEN_W'(1) << rb_lv;
  assign rb_half = LEN_W'(1) << (rb_lv - LVL_W'(1));
  assign qlen    = {1'b0, qr} - {1'b0, ql} + LEN_W'(1);
  assign qs      = flog2(qlen);
  assign qspan   = LEN_W'(1) << qs;
  assign qb      = {1'b0, qr} + LEN_W'(1) - qspan;
  assign mid     = lo + ((hiex - LEN_W'(1) - lo) >> 1);

  always_comb begin
    stat.kind      = kind_q;
    stat.err       = err;
    stat.valid     = valid;
    stat.rb_lv_end = (rb_lv == LVL_W'(LEVELS));
    stat.rb_row_ok = ({1'b0, rb_i} + {1'b0, rb_span}) <= {1'b0, n};
    stat.gcd_done  = gdone;
    stat.ex_more   = lo < hiex;
  end

  always_comb begin
    case (cmd.rd_sel)
      RD_RB_A: raddr = {rb_lv - LVL_W'(1), rb_i[IDX_W-1:0]};
      RD_RB_B: raddr = {rb_lv - LVL_W'(1), rb_i[IDX_W-1:0] + rb_half[IDX_W-1:0]};
      RD_Q_A:  raddr = {qs, ql};
      RD_Q_B:  raddr = {qs, qb[IDX_W-1:0]};
      default: raddr = '0;
    endcase
  end

  // loads go straight into level zero of the table
  assign we    = cmd.wr_load || cmd.rb_write;
  assign waddr = cmd.wr_load ? {LVL_W'(0), a_q} : {rb_lv, rb_i[IDX_W-1:0]};
  assign wdata = cmd.wr_load ? v_q : gres;

  sptg_ram #(.WIDTH(VAL_W), .DEPTH(TBL_DEPTH)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  sptg_gcd u_gcd (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.gcd_start),
    .in_a   (op_a),
    .in_b   (rdata),
    .done   (gdone),
    .result (gres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      len   <= LEN_W'(1);
      valid <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= cmd.out_fire;
      if (cfg_we) len <= cfg_data;
      if (cfg_we || cmd.wr_load) valid <= 1'b0;
      else if (cmd.set_valid)    valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      kind_q <= kind_t'(kind);
      a_q    <= first_index;
      b_q    <= second_index;
      v_q    <= value;
    end
    if (cmd.rb_init) begin
      rb_lv <= LVL_W'(1);
      rb_i  <= '0;
    end else if (cmd.rb_next_lv) begin
      rb_lv <= rb_lv + LVL_W'(1);
      rb_i  <= '0;
    end else if (cmd.rb_write) begin
      rb_i <= rb_i + LEN_W'(1);
    end
    if (cmd.cap_a) op_a <= rdata;
    if (cmd.q_setup) begin
      ql <= a_q;
      qr <= b_q;
    end else if (cmd.ex_setup) begin
      ql <= b_q;
      qr <= mid[IDX_W-1:0];
    end
    if (cmd.ex_init) begin
      lo   <= {1'b0, a_q};
      hiex <= n;
      ans  <= a_q;
    end else if (cmd.ex_update) begin
      if (gres == v_q) begin
        ans <= qr;
        lo  <= {1'b0, qr} + LEN_W'(1);
      end else begin
        hiex <= {1'b0, qr};
      end
    end
    if (cmd.out_fire) begin
      error      <= err;
      gcd_result <= (kind_q == KIND_QUERY && !err) ? gres : '0;
      end_index  <= (kind_q == KIND_EXTEND && !err) ? ans : '0;
    end
  end

endmodule
`default_nettype wire

### hdl/sptg_ctrl.sv
`default_nettype none
module sptg_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire sptg_pkg::stat_t stat,
  output sptg_pkg::cmd_t       cmd,
  output logic                 busy
);
  import sptg_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  assign busy = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (start) state_next = ST_DECODE;
      ST_DECODE: begin
        if (stat.err || stat.kind == KIND_LOAD) state_next = ST_DONE;
        else if (!stat.valid)                   state_next = ST_RB_CHK;
        else                                    state_next = ST_OP;
      end
      ST_RB_CHK: begin
        if (stat.rb_lv_end)      state_next = ST_OP;
        else if (stat.rb_row_ok) state_next = ST_RB_RA;
      end
      ST_RB_RA:   state_next = ST_RB_RB;
      ST_RB_RB:   state_next = ST_RB_CB;
      ST_RB_CB:   state_next = ST_RB_WAIT;
      ST_RB_WAIT: if (stat.gcd_done) state_next = ST_RB_CHK;
      ST_OP: begin
        if (stat.kind == KIND_QUERY) state_next = ST_Q_RA;
        else                         state_next = ST_EX_CHK;
      end
      ST_Q_RA:   state_next = ST_Q_RB;
      ST_Q_RB:   state_next = ST_Q_CB;
      ST_Q_CB:   state_next = ST_Q_WAIT;
      ST_Q_WAIT: begin
        if (stat.gcd_done) begin
          if (stat.kind == KIND_QUERY) state_next = ST_DONE;
          else                         state_next = ST_EX_CHK;
        end
      end
      ST_EX_CHK: begin
        if (stat.ex_more) state_next = ST_Q_RA;
        else              state_next = ST_DONE;
      end
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RD_Q_A;
    case (state)
      ST_IDLE:   cmd.latch_in = start;
      ST_DECODE: begin
        cmd.wr_load = !stat.err && stat.kind == KIND_LOAD;
        cmd.rb_init = !stat.err && stat.kind != KIND_LOAD && !stat.valid;
      end
      ST_RB_CHK: begin
        cmd.set_valid  = stat.rb_lv_end;
        cmd.rb_next_lv = !stat.rb_lv_end && !stat.rb_row_ok;
      end
      ST_RB_RA: cmd.rd_sel = RD_RB_A;
      ST_RB_RB: begin
        cmd.rd_sel = RD_RB_B;
        cmd.cap_a  = 1'b1;
      end
      ST_RB_CB:   cmd.gcd_start = 1'b1;
      ST_RB_WAIT: cmd.rb_write  = stat.gcd_done;
      ST_OP: begin
        cmd.q_setup = stat.kind == KIND_QUERY;
        cmd.ex_init = stat.kind != KIND_QUERY;
      end
      ST_Q_RA: cmd.rd_sel = RD_Q_A;
      ST_Q_RB: begin
        cmd.rd_sel = RD_Q_B;
        cmd.cap_a  = 1'b1;
      end
      ST_Q_CB:   cmd.gcd_start = 1'b1;
      ST_Q_WAIT: cmd.ex_update = stat.gcd_done && stat.kind == KIND_EXTEND;
      ST_EX_CHK: cmd.ex_setup  = stat.ex_more;
      ST_DONE:   cmd.out_fire  = 1'b1;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### hdl/sparse_table_range_gcd.sv
// Range GCD engine over up to 1024 elements with a sparse table of GCDs.
// Input: drive kind, first_index, second_index and value with start high;
// the item is taken at an edge where start is high and busy is low.
// kind 0 loads an element, 1 returns gcd over [first..second], 2 searches
// from first_index for the furthest end whose GCD from the anchor
// second_index equals value. Kind 3 and bad indices report error.
// Result: done pulses for one cycle with gcd_result, end_index and error;
// there is no backpressure, the receiver must take it.
// Config: cfg_we with cfg_data writes length. The user must write it only
// while the block is idle; the block does not enforce this itself. A query
// reads two table entries and runs one binary gcd on them (one shift or
// subtract per cycle). An extend runs up to 11 such probes. The first
// query or extend after a load or length write first rebuilds the table:
// one gcd per entry on levels 1 to 10, through the single table RAM.
// Reset clears the controller, sets length to 1 and marks the table stale;
// table contents are undefined until loaded.
`default_nettype none
module sparse_table_range_gcd (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [1:0]                 kind,
  input  wire logic [sptg_pkg::IDX_W-1:0] first_index,
  input  wire logic [sptg_pkg::IDX_W-1:0] second_index,
  input  wire logic [sptg_pkg::VAL_W-1:0] value,
  input  wire logic                       cfg_we,
  input  wire logic [sptg_pkg::LEN_W-1:0] cfg_data,
  output logic                            done,
  output logic      [sptg_pkg::VAL_W-1:0] gcd_result,
  output logic      [sptg_pkg::IDX_W-1:0] end_index,
  output logic                            error
);
  import sptg_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  sptg_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  sptg_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .kind         (kind),
    .first_index  (first_index),
    .second_index (second_index),
    .value        (value),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .done         (done),
    .gcd_result   (gcd_result),
    .end_index    (end_index),
    .error        (error)
  );

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    done && error |-> gcd_result == '0 && end_index == '0)
    else $error("rejected item carries nonzero fields");

  a_one_done: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");

endmodule
`default_nettype wire
